// ===== src/frr_pkg.sv =====
// Shared types and constants of the right-angle frame rotator.
`timescale 1ns / 1ps
`default_nettype none

package frr_pkg;

    // Field widths of the item channels and the configuration port
    localparam int SAMPLE_W       = 8;
    localparam int PORT_LANES     = 3;
    localparam int CFG_DATA_W     = 9;
    localparam int CFG_INDEX_W    = 2;
    localparam int ROT_W          = 2;
    localparam int CHAN_CNT_W     = 2;

    // Item operations
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_CODE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd3;

    // Clockwise rotation codes
    localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] SRC_WIDTH_RESET     = 9'd256;
    localparam logic [CFG_DATA_W-1:0] SRC_HEIGHT_RESET    = 9'd256;
    localparam logic [ROT_W-1:0]      ROTATION_CODE_RESET = ROT_0;
    localparam logic [CHAN_CNT_W-1:0] CHANNEL_COUNT_RESET = 2'd3;

endpackage

`default_nettype wire

// ===== src/frr_if.sv =====
// Valid/ready channel interfaces for rotator items and results.
`timescale 1ns / 1ps
`default_nettype none

interface frr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [frr_pkg::SAMPLE_W-1:0]  in_ch0;
    logic [frr_pkg::SAMPLE_W-1:0]  in_ch1;
    logic [frr_pkg::SAMPLE_W-1:0]  in_ch2;

    modport source (output valid, opcode, in_ch0, in_ch1, in_ch2, input ready);
    modport sink (input valid, opcode, in_ch0, in_ch1, in_ch2, output ready);
endinterface

interface frr_out_if;
    logic                          valid;
    logic                          ready;
    logic [frr_pkg::SAMPLE_W-1:0]  out_ch0;
    logic [frr_pkg::SAMPLE_W-1:0]  out_ch1;
    logic [frr_pkg::SAMPLE_W-1:0]  out_ch2;
    logic                          frame_last;

    modport source (output valid, out_ch0, out_ch1, out_ch2, frame_last, input ready);
    modport sink (input valid, out_ch0, out_ch1, out_ch2, frame_last, output ready);
endinterface

`default_nettype wire

// ===== src/frame_rotate_right_angle.sv =====
// Top level of the right-angle frame rotator.
// Rotates one frame clockwise by 0, 90, 180 or 270 degrees. Load items write
// source pixels, given in raster order, straight to their rotated place in a
// MAX_WIDTH*MAX_HEIGHT frame store; fetch items read the store back in
// destination raster order and flag the last pixel of the frame. One item is
// taken every cycle while a stalled output does not hold the read stage, loads
// and fetches mixed freely: each item is a single access to one port of the
// store (loads use the write port, fetches the read port). A fetch result passes
// through the store read register, then the output register. Fetches before a
// whole frame has been loaded are taken and dropped without a result. Writing
// width, height or rotation restarts loading and reading at the first pixel. The
// store is not cleared after reset and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module frame_rotate_right_angle #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_HEIGHT   = 256,
    parameter int MAX_CHANNELS = 3
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [frr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [frr_pkg::CFG_DATA_W-1:0]      cfg_data,
    frr_in_if.sink                                   req,
    frr_out_if.source                                rsp
);

    localparam int NL    = (MAX_CHANNELS < frr_pkg::PORT_LANES) ? MAX_CHANNELS
                                                                : frr_pkg::PORT_LANES;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WD    = $clog2(MAX_WIDTH + 1);
    localparam int HD    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = (CW > RW) ? CW : RW;
    localparam int DIMW  = (WD > HD) ? WD : HD;
    localparam int PW    = XW + DIMW;
    localparam int TW    = WD + HD;
    localparam int SW    = frr_pkg::SAMPLE_W;
    localparam int CHAN_CNT_W_L = frr_pkg::CHAN_CNT_W;

    // Configuration registers
    logic [frr_pkg::CFG_DATA_W-1:0] src_width_reg;
    logic [frr_pkg::CFG_DATA_W-1:0] src_height_reg;
    logic [frr_pkg::ROT_W-1:0]      rotation_code_reg;
    logic [frr_pkg::CHAN_CNT_W-1:0] channel_count_reg;

    // Frame position state
    logic [CW-1:0]  load_col_reg, load_col_next;
    logic [RW-1:0]  load_row_reg, load_row_next;
    logic [AW-1:0]  read_addr_reg, read_addr_next;
    logic           frame_ready_reg, frame_ready_next;

    // Read stage and output register
    logic           s1_valid_reg;
    logic           s1_last_reg;
    logic           out_valid_reg;
    logic [SW-1:0]  out_lane_reg [frr_pkg::PORT_LANES];
    logic           out_last_reg;

    logic           restart;
    logic           s1_move;
    logic           item_acc;
    logic           load_acc;
    logic           fetch_acc;
    logic           fetch_hit;

    logic [WD-1:0]  eff_w, w_m1;
    logic [HD-1:0]  eff_h, h_m1;
    logic [CHAN_CNT_W_L-1:0] eff_cc;
    logic [XW-1:0]  dx, dy;
    logic [DIMW-1:0] dw;
    logic [PW-1:0]  prod;
    logic [AW-1:0]  wr_addr;
    logic [TW-1:0]  total;
    logic           fetch_last;

    logic [SW-1:0]    in_lane [frr_pkg::PORT_LANES];
    logic [NL*SW-1:0] ram_wdata;
    logic [NL*SW-1:0] ram_rdata;
    logic [frr_pkg::PORT_LANES-1:0] lane_keep;

    // Clamp dimensions and channel count into their legal ranges
    always_comb
    begin
        if (src_width_reg == '0)
        begin
            eff_w = WD'(1);
        end
        else if (32'(src_width_reg) > MAX_WIDTH)
        begin
            eff_w = WD'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WD'(src_width_reg);
        end

        if (src_height_reg == '0)
        begin
            eff_h = HD'(1);
        end
        else if (32'(src_height_reg) > MAX_HEIGHT)
        begin
            eff_h = HD'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HD'(src_height_reg);
        end

        if (channel_count_reg == '0)
        begin
            eff_cc = CHAN_CNT_W_L'(1);
        end
        else if (32'(channel_count_reg) > NL)
        begin
            eff_cc = CHAN_CNT_W_L'(NL);
        end
        else
        begin
            eff_cc = channel_count_reg;
        end

        w_m1 = eff_w - WD'(1);
        h_m1 = eff_h - HD'(1);
    end

    // Mark lanes below the channel count
    always_comb
    begin
        for (int i = 0; i < frr_pkg::PORT_LANES; i++)
        begin
            lane_keep[i] = (i < NL) && (32'(eff_cc) > i);
        end
    end

    // Handshake: accept while the read stage is free or drains this cycle
    assign s1_move   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_move;
    assign item_acc  = req.valid && req.ready;
    assign load_acc  = item_acc && (req.opcode == frr_pkg::OP_LOAD);
    assign fetch_acc = item_acc && (req.opcode == frr_pkg::OP_FETCH);
    assign fetch_hit = fetch_acc && frame_ready_reg;

    assign restart = cfg_we && ((cfg_index == frr_pkg::REG_SRC_WIDTH) ||
                                (cfg_index == frr_pkg::REG_SRC_HEIGHT) ||
                                (cfg_index == frr_pkg::REG_ROTATION_CODE));

    // Map the source position to its rotated place
    always_comb
    begin
        case (rotation_code_reg)
            frr_pkg::ROT_0:
            begin
                dx = XW'(load_col_reg);
                dy = XW'(load_row_reg);
                dw = DIMW'(eff_w);
            end
            frr_pkg::ROT_90:
            begin
                dx = XW'(h_m1 - HD'(load_row_reg));
                dy = XW'(load_col_reg);
                dw = DIMW'(eff_h);
            end
            frr_pkg::ROT_180:
            begin
                dx = XW'(w_m1 - WD'(load_col_reg));
                dy = XW'(h_m1 - HD'(load_row_reg));
                dw = DIMW'(eff_w);
            end
            default:
            begin
                dx = XW'(load_row_reg);
                dy = XW'(w_m1 - WD'(load_col_reg));
                dw = DIMW'(eff_h);
            end
        endcase
    end

    assign prod    = PW'(dy) * PW'(dw);
    assign wr_addr = AW'(prod + PW'(dx));

    // Frame size and last-pixel flag for the read side
    assign total      = TW'(eff_w) * TW'(eff_h);
    assign fetch_last = (TW'(read_addr_reg) + TW'(1)) >= total;

    // Mask the incoming samples to the active lanes
    assign in_lane[0] = req.in_ch0;
    assign in_lane[1] = req.in_ch1;
    assign in_lane[2] = req.in_ch2;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            ram_wdata[i*SW +: SW] = lane_keep[i] ? in_lane[i] : '0;
        end
    end

    // Advance load and read positions
    always_comb
    begin
        load_col_next    = load_col_reg;
        load_row_next    = load_row_reg;
        read_addr_next   = read_addr_reg;
        frame_ready_next = frame_ready_reg;

        if (restart)
        begin
            load_col_next    = '0;
            load_row_next    = '0;
            read_addr_next   = '0;
            frame_ready_next = 1'b0;
        end
        else if (load_acc)
        begin
            frame_ready_next = 1'b0;
            if (WD'(load_col_reg) == w_m1)
            begin
                load_col_next = '0;
                if (HD'(load_row_reg) == h_m1)
                begin
                    load_row_next    = '0;
                    frame_ready_next = 1'b1;
                end
                else
                begin
                    load_row_next = load_row_reg + RW'(1);
                end
            end
            else
            begin
                load_col_next = load_col_reg + CW'(1);
            end
        end
        else if (fetch_hit)
        begin
            read_addr_next = fetch_last ? '0 : read_addr_reg + AW'(1);
        end
    end

    // Hold configuration and position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg     <= frr_pkg::SRC_WIDTH_RESET;
            src_height_reg    <= frr_pkg::SRC_HEIGHT_RESET;
            rotation_code_reg <= frr_pkg::ROTATION_CODE_RESET;
            channel_count_reg <= frr_pkg::CHANNEL_COUNT_RESET;
            load_col_reg      <= '0;
            load_row_reg      <= '0;
            read_addr_reg     <= '0;
            frame_ready_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    frr_pkg::REG_SRC_WIDTH:     src_width_reg     <= cfg_data;
                    frr_pkg::REG_SRC_HEIGHT:    src_height_reg    <= cfg_data;
                    frr_pkg::REG_ROTATION_CODE:
                        rotation_code_reg <= cfg_data[frr_pkg::ROT_W-1:0];
                    frr_pkg::REG_CHANNEL_COUNT:
                        channel_count_reg <= cfg_data[frr_pkg::CHAN_CNT_W-1:0];
                    default: ;
                endcase
            end
            load_col_reg    <= load_col_next;
            load_row_reg    <= load_row_next;
            read_addr_reg   <= read_addr_next;
            frame_ready_reg <= frame_ready_next;
        end
    end

    // Frame store
    frr_ram #(
        .WIDTH (NL * SW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (load_acc),
        .waddr (wr_addr),
        .wdata (ram_wdata),
        .re    (fetch_hit),
        .raddr (read_addr_reg),
        .rdata (ram_rdata)
    );

    // Track the read stage and hold the last flag with it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            if (!s1_valid_reg || s1_move)
            begin
                s1_valid_reg <= fetch_hit;
            end
            if (fetch_hit)
            begin
                s1_last_reg <= fetch_last;
            end
        end
    end

    // Output valid: load from the read stage, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, masked to the active lanes
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            for (int i = 0; i < frr_pkg::PORT_LANES; i++)
            begin
                if (i < NL)
                begin
                    out_lane_reg[i] <= lane_keep[i] ? ram_rdata[(i % NL)*SW +: SW] : '0;
                end
                else
                begin
                    out_lane_reg[i] <= '0;
                end
            end
            out_last_reg <= s1_last_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.out_ch0    = out_lane_reg[0];
    assign rsp.out_ch1    = out_lane_reg[1];
    assign rsp.out_ch2    = out_lane_reg[2];
    assign rsp.frame_last = out_last_reg;

    // A full pipeline with a stalled output must stop intake
    a_stall_blocks_intake: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("item taken while result path is stalled");

    // A frame only becomes readable through a load
    a_ready_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_ready_reg) |-> $past(load_acc))
        else $error("frame marked ready without a load");

    // Load positions stay inside the current frame
    a_load_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (WD'(load_col_reg) < eff_w) && (HD'(load_row_reg) < eff_h))
        else $error("load position outside the frame");

    // Read position stays inside the current frame
    a_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        TW'(read_addr_reg) < total)
        else $error("read position outside the frame");

    // A read stage entry always moves on once the output is free
    a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("read stage did not advance into a free output");

endmodule

`default_nettype wire

// ===== src/frr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module frr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, hold data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
